[rtl/core/sft_pkg.sv]
// sft_pkg: types and byte codes for the stuffed frame transmitter
// no dependencies; used by stuffed_frame_transmitter_unit
`default_nettype none

package sft_pkg;

    // framing and stuffing bytes
    localparam logic [7:0] FLAG_BYTE     = 8'h7E;
    localparam logic [7:0] ESC_BYTE      = 8'h7D;
    localparam logic [7:0] ESC_FLAG_BYTE = 8'h5E;
    localparam logic [7:0] ESC_ESC_BYTE  = 8'h5D;

    // control bytes
    localparam logic [7:0] CTRL_I0   = 8'h00;
    localparam logic [7:0] CTRL_I1   = 8'h40;
    localparam logic [7:0] CTRL_RR0  = 8'h05;
    localparam logic [7:0] CTRL_RR1  = 8'h85;
    localparam logic [7:0] CTRL_REJ0 = 8'h01;
    localparam logic [7:0] CTRL_REJ1 = 8'h81;

    // register reset values
    localparam logic [7:0] FRAME_ADDRESS_RESET = 8'h01;
    localparam logic [7:0] REPLY_ADDRESS_RESET = 8'h03;
    localparam logic [3:0] MAX_ATTEMPTS_RESET  = 4'd3;

    localparam logic [3:0] REJECT_LIMIT = 4'd15;

    // most line bytes one request can produce
    localparam int MaxResults = 9;
    localparam int CountWidth = $clog2(MaxResults + 1);

    typedef enum logic [1:0] {
        REG_FRAME_ADDRESS = 2'd0,
        REG_REPLY_ADDRESS = 2'd1,
        REG_MAX_ATTEMPTS  = 2'd2,
        REG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef enum logic [0:0] {
        CMD_PAYLOAD = 1'b0,
        CMD_LINE    = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        PS_START = 3'd0,
        PS_FLAG  = 3'd1,
        PS_ADDR  = 3'd2,
        PS_CTRL  = 3'd3,
        PS_CHECK = 3'd4
    } parse_state_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_RR      = 2'd1,
        EV_REJ     = 2'd2,
        EV_GAVE_UP = 2'd3
    } reply_event_t;

endpackage

`default_nettype wire

[rtl/core/stuffed_frame_transmitter_unit.sv]
// stuffed_frame_transmitter_unit: hdlc-style framer with stop-and-wait reply handling
// depends on sft_pkg for byte codes, parser states and event codes
// the first result of a request appears in the cycle after it is accepted
// throughput: one result per cycle while out_ready is high; a request has 1 to 9
//   results, drained by the single output shift buffer one byte a cycle
// the next request is taken in the cycle its predecessor's last result leaves
// reset: asynchronous, active low; clears all link state and loads register defaults
`default_nettype none

module stuffed_frame_transmitter_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // request channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       line_byte,
    output logic             line_valid,
    output logic             run_last,
    output logic [1:0]       reply_event,
    output logic             sequence_now,
    output logic [3:0]       attempt_count
);

    localparam int Depth = sft_pkg::MaxResults;
    localparam int CntW  = sft_pkg::CountWidth;

    // configuration registers
    logic [7:0] frame_address_reg;
    logic [7:0] reply_address_reg;
    logic [3:0] max_attempts_reg;

    // link state
    logic                  sequence_bit_reg, sequence_bit_next;
    logic [3:0]            rejection_count_reg, rejection_count_next;
    logic [7:0]            check_acc_reg, check_acc_next;
    logic                  inside_frame_reg, inside_frame_next;
    sft_pkg::parse_state_t parse_state_reg, parse_state_next;
    logic [7:0]            reply_control_reg, reply_control_next;
    sft_pkg::reply_event_t event_next;

    // output shift buffer: entry 0 is the byte on the port
    logic [7:0]            bytes_reg [Depth];
    logic [7:0]            bytes_next [Depth];
    logic [CntW-1:0]       count_reg, count_next;
    logic                  line_valid_reg;
    sft_pkg::reply_event_t event_reg;
    logic                  seq_out_reg;
    logic [3:0]            attempt_out_reg;

    logic in_fire;
    logic out_fire;
    logic is_line;

    assign cfg_ready = 1'b1;
    assign is_line   = (sft_pkg::command_t'(command) == sft_pkg::CMD_LINE);

    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid && out_ready;
    // take a new request once the buffer drains, including its last byte leaving now
    assign in_ready  = (count_reg == '0) || ((count_reg == CntW'(1)) && out_ready);
    assign in_fire   = in_valid && in_ready;

    assign line_byte     = bytes_reg[0];
    assign line_valid    = line_valid_reg;
    assign run_last      = (count_reg == CntW'(1));
    assign reply_event   = event_reg;
    assign sequence_now  = seq_out_reg;
    assign attempt_count = attempt_out_reg;

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_address_reg <= sft_pkg::FRAME_ADDRESS_RESET;
            reply_address_reg <= sft_pkg::REPLY_ADDRESS_RESET;
            max_attempts_reg  <= sft_pkg::MAX_ATTEMPTS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (sft_pkg::cfg_index_t'(cfg_index))
                sft_pkg::REG_FRAME_ADDRESS: frame_address_reg <= cfg_data;
                sft_pkg::REG_REPLY_ADDRESS: reply_address_reg <= cfg_data;
                sft_pkg::REG_MAX_ATTEMPTS:  max_attempts_reg  <= cfg_data[3:0];
                default:                    ;
            endcase
        end
    end

    // reply parser: next state
    always_comb
    begin
        parse_state_next   = parse_state_reg;
        reply_control_next = reply_control_reg;
        case (parse_state_reg)
            sft_pkg::PS_START:
            begin
                if (data_byte == sft_pkg::FLAG_BYTE)
                    parse_state_next = sft_pkg::PS_FLAG;
            end
            sft_pkg::PS_FLAG:
            begin
                if (data_byte == reply_address_reg)
                    parse_state_next = sft_pkg::PS_ADDR;
                else if (data_byte != sft_pkg::FLAG_BYTE)
                    parse_state_next = sft_pkg::PS_START;
            end
            sft_pkg::PS_ADDR:
            begin
                if (data_byte == sft_pkg::CTRL_RR0 || data_byte == sft_pkg::CTRL_RR1 ||
                    data_byte == sft_pkg::CTRL_REJ0 || data_byte == sft_pkg::CTRL_REJ1)
                begin
                    reply_control_next = data_byte;
                    parse_state_next   = sft_pkg::PS_CTRL;
                end
                else if (data_byte == sft_pkg::FLAG_BYTE)
                    parse_state_next = sft_pkg::PS_FLAG;
                else
                    parse_state_next = sft_pkg::PS_START;
            end
            sft_pkg::PS_CTRL:
            begin
                if (data_byte == (reply_address_reg ^ reply_control_reg))
                    parse_state_next = sft_pkg::PS_CHECK;
                else
                    parse_state_next = sft_pkg::PS_START;
            end
            sft_pkg::PS_CHECK: parse_state_next = sft_pkg::PS_START;
            default:           parse_state_next = sft_pkg::PS_START;
        endcase
    end

    // reply parser: outputs (event, sequence bit, rejection count)
    always_comb
    begin
        logic [3:0] bumped;
        bumped               = rejection_count_reg;
        event_next           = sft_pkg::EV_NONE;
        sequence_bit_next    = sequence_bit_reg;
        rejection_count_next = rejection_count_reg;
        case (parse_state_reg)
            sft_pkg::PS_CHECK:
            begin
                if (data_byte == sft_pkg::FLAG_BYTE)
                begin
                    if (reply_control_reg == sft_pkg::CTRL_RR0 ||
                        reply_control_reg == sft_pkg::CTRL_RR1)
                    begin
                        sequence_bit_next    = ~sequence_bit_reg;
                        rejection_count_next = '0;
                        event_next           = sft_pkg::EV_RR;
                    end
                    else
                    begin
                        // saturating count, then compare against the attempt maximum
                        if (rejection_count_reg < sft_pkg::REJECT_LIMIT)
                            bumped = rejection_count_reg + 4'd1;
                        if (bumped >= max_attempts_reg)
                        begin
                            rejection_count_next = '0;
                            event_next           = sft_pkg::EV_GAVE_UP;
                        end
                        else
                        begin
                            rejection_count_next = bumped;
                            event_next           = sft_pkg::EV_REJ;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // frame builder: lays out the line bytes of one payload request
    always_comb
    begin
        logic [3:0] pos;
        logic [7:0] ctl;
        logic [7:0] acc;
        logic [7:0] acc_new;
        pos     = '0;
        ctl     = sequence_bit_reg ? sft_pkg::CTRL_I1 : sft_pkg::CTRL_I0;
        acc     = inside_frame_reg ? check_acc_reg : 8'h00;
        acc_new = acc ^ data_byte;
        for (int i = 0; i < Depth; i++)
            bytes_next[i] = 8'h00;
        check_acc_next    = check_acc_reg;
        inside_frame_next = inside_frame_reg;

        if (!is_line)
        begin
            // header on the first byte of a frame, never stuffed
            if (!inside_frame_reg)
            begin
                bytes_next[0] = sft_pkg::FLAG_BYTE;
                bytes_next[1] = frame_address_reg;
                bytes_next[2] = ctl;
                bytes_next[3] = frame_address_reg ^ ctl;
                pos           = 4'd4;
            end
            // stuffed payload byte
            if (data_byte == sft_pkg::FLAG_BYTE)
            begin
                bytes_next[pos]        = sft_pkg::ESC_BYTE;
                bytes_next[pos + 4'd1] = sft_pkg::ESC_FLAG_BYTE;
                pos                    = pos + 4'd2;
            end
            else if (data_byte == sft_pkg::ESC_BYTE)
            begin
                bytes_next[pos]        = sft_pkg::ESC_BYTE;
                bytes_next[pos + 4'd1] = sft_pkg::ESC_ESC_BYTE;
                pos                    = pos + 4'd2;
            end
            else
            begin
                bytes_next[pos] = data_byte;
                pos             = pos + 4'd1;
            end
            // trailer: stuffed check and closing flag
            if (last_byte)
            begin
                if (acc_new == sft_pkg::FLAG_BYTE)
                begin
                    bytes_next[pos]        = sft_pkg::ESC_BYTE;
                    bytes_next[pos + 4'd1] = sft_pkg::ESC_FLAG_BYTE;
                    pos                    = pos + 4'd2;
                end
                else if (acc_new == sft_pkg::ESC_BYTE)
                begin
                    bytes_next[pos]        = sft_pkg::ESC_BYTE;
                    bytes_next[pos + 4'd1] = sft_pkg::ESC_ESC_BYTE;
                    pos                    = pos + 4'd2;
                end
                else
                begin
                    bytes_next[pos] = acc_new;
                    pos             = pos + 4'd1;
                end
                bytes_next[pos]   = sft_pkg::FLAG_BYTE;
                pos               = pos + 4'd1;
                check_acc_next    = 8'h00;
                inside_frame_next = 1'b0;
            end
            else
            begin
                check_acc_next    = acc_new;
                inside_frame_next = 1'b1;
            end
            count_next = CntW'(pos);
        end
        else
        begin
            // line request: one status result, no byte to send
            count_next = CntW'(1);
        end
    end

    // link state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sequence_bit_reg    <= 1'b0;
            rejection_count_reg <= '0;
            check_acc_reg       <= '0;
            inside_frame_reg    <= 1'b0;
            parse_state_reg     <= sft_pkg::PS_START;
            reply_control_reg   <= '0;
        end
        else if (in_fire)
        begin
            if (is_line)
            begin
                sequence_bit_reg    <= sequence_bit_next;
                rejection_count_reg <= rejection_count_next;
                parse_state_reg     <= parse_state_next;
                reply_control_reg   <= reply_control_next;
            end
            else
            begin
                check_acc_reg    <= check_acc_next;
                inside_frame_reg <= inside_frame_next;
            end
        end
    end

    // result count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (in_fire)
            count_reg <= count_next;
        else if (out_fire)
            count_reg <= count_reg - CntW'(1);
    end

    // result payload: load on a request, shift as bytes are taken
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < Depth; i++)
                bytes_reg[i] <= bytes_next[i];
            line_valid_reg <= !is_line;
            if (is_line)
            begin
                event_reg       <= event_next;
                seq_out_reg     <= sequence_bit_next;
                attempt_out_reg <= rejection_count_next;
            end
            else
            begin
                event_reg       <= sft_pkg::EV_NONE;
                seq_out_reg     <= sequence_bit_reg;
                attempt_out_reg <= rejection_count_reg;
            end
        end
        else if (out_fire)
        begin
            for (int i = 0; i < Depth - 1; i++)
                bytes_reg[i] <= bytes_reg[i + 1];
            bytes_reg[Depth - 1] <= 8'h00;
        end
    end

endmodule

`default_nettype wire
